// ===== design/gradient_bar_test_pattern_top_macros.svh =====
// Assertion macros shared by the gradient bar test pattern design.
`ifndef GRADIENT_BAR_TEST_PATTERN_TOP_MACROS_SVH
`define GRADIENT_BAR_TEST_PATTERN_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that the antecedent implies the consequent in the same cycle.
`define GBTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gbtp assertion failed: same-cycle implication");

// Check that the antecedent implies the consequent in the next cycle.
`define GBTP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gbtp assertion failed: next-cycle implication");

`else

`define GBTP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GBTP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/gbtp_pkg.sv =====
// Shared types and constants for the gradient bar test pattern generator.
package gbtp_pkg;

    // Configuration register geometry
    localparam int REG_W = 13;
    localparam int MAX_DIMENSION_DEFAULT = 4096;
    localparam logic [REG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [REG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_FRAME_WIDTH  = 1'b0;
    localparam t_cfg_idx REG_FRAME_HEIGHT = 1'b1;

    // Pixel bytes
    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

    // Ramp divider: one quotient bit per step
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_W = $clog2(DIV_STEPS);
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step STEP_LAST = t_step'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic load;
    } t_cmd;

endpackage

// ===== design/gbtp_div.sv =====
// Restoring divider giving one bit of an 8-bit ramp quotient per cycle while i_step is high.
module gbtp_div
    import gbtp_pkg::*;
#(
    parameter int CW = 12
) (
    input  logic             i_clk,
    input  logic             i_start,
    input  logic             i_step,
    input  logic [CW+7:0]    i_numer,
    input  logic [CW-1:0]    i_denom,
    output logic [PIX_W-1:0] o_quot
);

    localparam int NW = CW + PIX_W;

    logic [NW-1:0]    r_rem, n_rem;
    logic [NW-1:0]    r_dsr, n_dsr;
    logic [PIX_W-1:0] r_quo, n_quo;

    // Load operands on start, then subtract the shifted divisor, when it fits, once per step
    always_comb begin
        n_rem = r_rem;
        n_dsr = r_dsr;
        n_quo = r_quo;
        if (i_start) begin
            n_rem = i_numer;
            n_dsr = NW'(i_denom) << (PIX_W - 1);
            n_quo = '0;
        end else if (i_step) begin
            if (r_rem >= r_dsr) begin
                n_rem = r_rem - r_dsr;
                n_quo = {r_quo[PIX_W-2:0], 1'b1};
            end else begin
                n_quo = {r_quo[PIX_W-2:0], 1'b0};
            end
            n_dsr = r_dsr >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
    end

    assign o_quot = r_quo;

endmodule

// ===== design/gbtp_datapath.sv =====
// Raster counters, configuration registers, ramp dividers and output register.
module gbtp_datapath
    import gbtp_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_buffer_free,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_index,
    input  logic [REG_W-1:0] i_cfg_data,
    output logic             o_pixel_valid,
    output logic [PIX_W-1:0] o_red,
    output logic [PIX_W-1:0] o_green,
    output logic [PIX_W-1:0] o_blue,
    output logic [PIX_W-1:0] o_alpha,
    output logic             o_start_of_frame,
    output logic             o_end_of_line,
    output logic             o_end_of_frame
);

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int NW = CW + PIX_W;
    localparam int EW = (CW + 1 > REG_W) ? CW + 1 : REG_W;

    logic [REG_W-1:0] r_width, r_height;
    logic [CW-1:0]    r_col, n_col;
    logic [CW-1:0]    r_row, n_row;
    logic [CW-1:0]    r_bar, n_bar;
    logic             r_active, n_active;

    logic             r_refused, r_sof, r_eol, r_eof, r_bar_hit;

    logic [CW-1:0]    last_w, last_h;
    logic [CW-1:0]    cur_col, cur_row, pos_x, pos_y;
    logic             refused, eol, eof, bar_hit;
    logic [NW-1:0]    numer_x, numer_y;
    logic [PIX_W-1:0] quot_x, quot_y;

    // Clamp a register to 2..MAX_DIMENSION and return the last coordinate
    function automatic logic [CW-1:0] last_coord(input logic [REG_W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        if (ext < EW'(2)) begin
            return CW'(1);
        end else if (ext > EW'(MAX_DIMENSION)) begin
            return CW'(MAX_DIMENSION - 1);
        end else begin
            return CW'(ext - EW'(1));
        end
    endfunction

    assign last_w = last_coord(r_width);
    assign last_h = last_coord(r_height);

    // Decode the current transaction against the raster position
    always_comb begin
        refused = !r_active && !i_buffer_free;
        cur_col = r_active ? r_col : '0;
        cur_row = r_active ? r_row : '0;
        bar_hit = (cur_col == r_bar);
        eol     = (cur_col >= last_w);
        eof     = eol && (cur_row >= last_h);
        pos_x   = (cur_col > last_w) ? last_w : cur_col;
        pos_y   = (cur_row > last_h) ? last_h : cur_row;
        numer_x = (NW'(pos_x) << PIX_W) - NW'(pos_x);
        numer_y = (NW'(pos_y) << PIX_W) - NW'(pos_y);
    end

    // Advance the raster on an accepted, non-refused transaction; clear the bar on a width write
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_bar    = r_bar;
        n_active = r_active;
        if (i_cmd.start && !refused) begin
            n_active = !eof;
            if (eol) begin
                n_col = '0;
                n_row = eof ? '0 : cur_row + CW'(1);
            end else begin
                n_col = cur_col + CW'(1);
                n_row = cur_row;
            end
            if (eof) begin
                n_bar = (r_bar >= last_w) ? '0 : r_bar + CW'(1);
            end
        end
        if (i_cfg_we && i_cfg_index == REG_FRAME_WIDTH) begin
            n_bar = '0;
        end
    end

    // Hold configuration and raster state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= FRAME_WIDTH_RESET;
            r_height <= FRAME_HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_bar    <= '0;
            r_active <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_FRAME_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == REG_FRAME_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            r_col    <= n_col;
            r_row    <= n_row;
            r_bar    <= n_bar;
            r_active <= n_active;
        end
    end

    // Capture per-transaction flags on start and hold them while the dividers run
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_refused <= refused;
            r_sof     <= !refused && !r_active;
            r_eol     <= !refused && eol;
            r_eof     <= !refused && eof;
            r_bar_hit <= bar_hit;
        end
    end

    gbtp_div #(.CW(CW)) u_div_x (
        .i_clk   (i_clk),
        .i_start (i_cmd.start),
        .i_step  (i_cmd.step),
        .i_numer (numer_x),
        .i_denom (last_w),
        .o_quot  (quot_x)
    );

    gbtp_div #(.CW(CW)) u_div_y (
        .i_clk   (i_clk),
        .i_start (i_cmd.start),
        .i_step  (i_cmd.step),
        .i_numer (numer_y),
        .i_denom (last_h),
        .o_quot  (quot_y)
    );

    // Load the output register with the finished pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_pixel_valid    <= !r_refused;
            o_start_of_frame <= r_sof;
            o_end_of_line    <= r_eol;
            o_end_of_frame   <= r_eof;
            if (r_refused) begin
                o_red   <= PIX_ZERO;
                o_green <= PIX_ZERO;
                o_blue  <= PIX_ZERO;
                o_alpha <= PIX_ZERO;
            end else if (r_bar_hit) begin
                o_red   <= PIX_FULL;
                o_green <= PIX_FULL;
                o_blue  <= PIX_FULL;
                o_alpha <= PIX_FULL;
            end else begin
                o_red   <= quot_x;
                o_green <= quot_y;
                o_blue  <= PIX_ZERO;
                o_alpha <= PIX_FULL;
            end
        end
    end

endmodule

// ===== design/gbtp_ctrl.sv =====
// Controller: input handshake, divider sequencing and output valid.
`include "gradient_bar_test_pattern_top_macros.svh"

module gbtp_ctrl
    import gbtp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_out_valid, n_out_valid;

    // Hold state, step count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequence one transaction: accept, divide, load
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_step      = '0;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + t_step'(1);
                if (r_step == STEP_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Set valid on load, drop it once the result is taken
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

    `GBTP_ASSERT_NXT(a_accept_starts_div, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_DIV && r_step == '0)
    `GBTP_ASSERT_IMP(a_load_needs_room, i_clk, i_rst_n, o_cmd.load, !r_out_valid || !i_out_stall)
    `GBTP_ASSERT_NXT(a_stalled_result_kept, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)
    `GBTP_ASSERT_NXT(a_div_finishes, i_clk, i_rst_n, r_state == S_DIV && r_step == STEP_LAST, r_state == S_DONE)

endmodule

// ===== design/gradient_bar_test_pattern_top.sv =====
// Top level of the gradient bar test pattern generator.
//
//   Port group    Direction  Handshake          Contents
//   in channel    in         i_in_valid/o_in_stall   buffer_free
//   out channel   out        o_out_valid/i_out_stall  pixel and frame markers
//   config        in         i_cfg_we           frame_width, frame_height
//
// An item is accepted, then stepped through the bit-per-cycle ramp dividers
// (red and green in parallel), then loaded into the output register.
// A finished pixel waits in the output register; the next item is accepted
// meanwhile and its load waits only while that register is still stalled.
// Reset (i_rst_n low, synchronous) restores 640x480, clears the raster and bar.
module gradient_bar_test_pattern_top
    import gbtp_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_buffer_free,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_pixel_valid,
    output logic [PIX_W-1:0] o_red,
    output logic [PIX_W-1:0] o_green,
    output logic [PIX_W-1:0] o_blue,
    output logic [PIX_W-1:0] o_alpha,
    output logic             o_start_of_frame,
    output logic             o_end_of_line,
    output logic             o_end_of_frame,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_index,
    input  logic [REG_W-1:0] i_cfg_data
);

    t_cmd cmd;

    gbtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    gbtp_datapath #(.MAX_DIMENSION(MAX_DIMENSION)) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_buffer_free    (i_buffer_free),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_pixel_valid    (o_pixel_valid),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_alpha          (o_alpha),
        .o_start_of_frame (o_start_of_frame),
        .o_end_of_line    (o_end_of_line),
        .o_end_of_frame   (o_end_of_frame)
    );

endmodule
